FILE: hdl/ppc_pkg.sv
// Shared types and constants for the planar pose composer.
// Holds the word layouts, fixed-point widths and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package ppc_pkg;

  // Field widths of the words
  localparam int COORD_BITS = 32;
  localparam int ANGLE_BITS = 16;

  // Default number of CORDIC micro-rotations
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;

  // CORDIC datapath: Q2.30 vector, 32-bit binary angle, kept with headroom
  localparam int CW         = 34;
  localparam int TRIG_BITS  = 32;
  localparam int FRAC_SHIFT = 30;
  localparam logic signed [CW-1:0] GAIN_Q30 = CW'(652032874);

  // Offset split for the multipliers: unsigned low part, signed high part
  localparam int LO_BITS = COORD_BITS / 2;
  localparam int HI_BITS = COORD_BITS - LO_BITS;
  localparam int PH_W    = TRIG_BITS + HI_BITS;
  localparam int PL_W    = TRIG_BITS + LO_BITS + 1;
  localparam int SUM_W   = TRIG_BITS + COORD_BITS + 2;
  localparam int TW      = SUM_W - FRAC_SHIFT;

  // atan(2^-i) as 32-bit binary angles
  localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [COORD_BITS-1:0] base_x;
    logic signed [COORD_BITS-1:0] base_y;
    logic        [ANGLE_BITS-1:0] base_heading;
    logic signed [COORD_BITS-1:0] rel_x;
    logic signed [COORD_BITS-1:0] rel_y;
    logic        [ANGLE_BITS-1:0] rel_heading;
  } ppc_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] global_x;
    logic signed [COORD_BITS-1:0] global_y;
    logic        [ANGLE_BITS-1:0] global_heading;
    logic                         saturated;
  } ppc_out_t;

  // CORDIC vector and residual angle
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } ppc_vec_t;

  // Fields riding alongside the rotation
  typedef struct packed {
    logic signed [COORD_BITS-1:0] base_x;
    logic signed [COORD_BITS-1:0] base_y;
    logic signed [COORD_BITS-1:0] rel_x;
    logic signed [COORD_BITS-1:0] rel_y;
    logic        [ANGLE_BITS-1:0] global_heading;
  } ppc_side_t;

endpackage

`default_nettype wire

FILE: hdl/planar_pose_compose.sv
// Planar pose composer: rotates the relative offset by the base heading
// (CORDIC sin/cos), adds the base position with saturation, sums headings.
// A word passes the CORDIC stage registers, then the M1, M2, M3 and M4 registers.
// Throughput: one word per cycle while out_stall is low; each stage holds one
// word and frees when the next stage takes it; bubbles close up under stall.
// Reset (synchronous, rst_n low) clears all valid bits; data registers keep.
`default_nettype none

module planar_pose_compose import ppc_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire ppc_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output ppc_out_t     out_data
);

  // ---------------------------------------------------------------------
  // Entry: fold heading into [-1/4, 1/4) turn, start vector (+-K, 0)
  // ---------------------------------------------------------------------
  logic [31:0] z32;
  logic        fold;
  ppc_vec_t    vec0;
  ppc_side_t   side0;

  assign z32  = {in_data.base_heading, (32 - ANGLE_BITS)'(0)};
  assign fold = z32[31] ^ z32[30];

  always_comb begin
    vec0.x = fold ? -GAIN_Q30 : GAIN_Q30;
    vec0.y = '0;
    vec0.z = CW'($signed({z32[31] ^ fold, z32[30:0]}));
  end

  always_comb begin
    side0.base_x         = in_data.base_x;
    side0.base_y         = in_data.base_y;
    side0.rel_x          = in_data.rel_x;
    side0.rel_y          = in_data.rel_y;
    side0.global_heading = in_data.base_heading + in_data.rel_heading;
  end

  // ---------------------------------------------------------------------
  // CORDIC pipeline
  // ---------------------------------------------------------------------
  logic      stg_valid [CORDIC_STAGES];
  ppc_vec_t  stg_vec   [CORDIC_STAGES];
  ppc_side_t stg_side  [CORDIC_STAGES];
  logic      stg_rdy   [CORDIC_STAGES];
  logic      m1_rdy;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    logic      v_in;
    ppc_vec_t  vec_in;
    ppc_side_t side_in;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign vec_in  = vec0;
      assign side_in = side0;
    end else begin : g_next
      assign v_in    = stg_valid[k-1];
      assign vec_in  = stg_vec[k-1];
      assign side_in = stg_side[k-1];
    end

    if (k == CORDIC_STAGES - 1) begin : g_rdy_last
      assign stg_rdy[k] = !stg_valid[k] || m1_rdy;
    end else begin : g_rdy_mid
      assign stg_rdy[k] = !stg_valid[k] || stg_rdy[k+1];
    end

    ppc_cordic_stage #(
      .STAGE(k)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .load    (stg_rdy[k]),
      .valid_in(v_in),
      .vec_in  (vec_in),
      .side_in (side_in),
      .valid_r (stg_valid[k]),
      .vec_r   (stg_vec[k]),
      .side_r  (stg_side[k])
    );
  end

  assign in_stall = !stg_rdy[0];

  // ---------------------------------------------------------------------
  // M1: partial products of cos/sin with split offsets
  // ---------------------------------------------------------------------
  logic signed [TRIG_BITS-1:0] cos_v;
  logic signed [TRIG_BITS-1:0] sin_v;
  logic signed [HI_BITS-1:0]   rx_hi;
  logic signed [HI_BITS-1:0]   ry_hi;
  logic signed [LO_BITS:0]     rx_lo;
  logic signed [LO_BITS:0]     ry_lo;
  ppc_side_t                   last_side;

  assign last_side = stg_side[CORDIC_STAGES-1];
  assign cos_v = stg_vec[CORDIC_STAGES-1].x[TRIG_BITS-1:0];
  assign sin_v = stg_vec[CORDIC_STAGES-1].y[TRIG_BITS-1:0];
  assign rx_hi = last_side.rel_x[COORD_BITS-1:LO_BITS];
  assign ry_hi = last_side.rel_y[COORD_BITS-1:LO_BITS];
  assign rx_lo = {1'b0, last_side.rel_x[LO_BITS-1:0]};
  assign ry_lo = {1'b0, last_side.rel_y[LO_BITS-1:0]};

  logic signed [PH_W-1:0] cxh_nxt, syh_nxt, sxh_nxt, cyh_nxt;
  logic signed [PL_W-1:0] cxl_nxt, syl_nxt, sxl_nxt, cyl_nxt;
  logic signed [PH_W-1:0] cxh_r, syh_r, sxh_r, cyh_r;
  logic signed [PL_W-1:0] cxl_r, syl_r, sxl_r, cyl_r;
  logic                   m1_valid_r;
  ppc_side_t              m1_side_r;
  logic                   m2_rdy;

  assign cxh_nxt = PH_W'(cos_v) * PH_W'(rx_hi);
  assign syh_nxt = PH_W'(sin_v) * PH_W'(ry_hi);
  assign sxh_nxt = PH_W'(sin_v) * PH_W'(rx_hi);
  assign cyh_nxt = PH_W'(cos_v) * PH_W'(ry_hi);
  assign cxl_nxt = PL_W'(cos_v) * PL_W'(rx_lo);
  assign syl_nxt = PL_W'(sin_v) * PL_W'(ry_lo);
  assign sxl_nxt = PL_W'(sin_v) * PL_W'(rx_lo);
  assign cyl_nxt = PL_W'(cos_v) * PL_W'(ry_lo);

  assign m1_rdy = !m1_valid_r || m2_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
    end else if (m1_rdy) begin
      m1_valid_r <= stg_valid[CORDIC_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (m1_rdy) begin
      cxh_r     <= cxh_nxt;
      syh_r     <= syh_nxt;
      sxh_r     <= sxh_nxt;
      cyh_r     <= cyh_nxt;
      cxl_r     <= cxl_nxt;
      syl_r     <= syl_nxt;
      sxl_r     <= sxl_nxt;
      cyl_r     <= cyl_nxt;
      m1_side_r <= last_side;
    end
  end

  // ---------------------------------------------------------------------
  // M2: combine high and low products per axis
  // ---------------------------------------------------------------------
  logic signed [PH_W:0] hx_r, hy_r;
  logic signed [PL_W:0] lx_r, ly_r;
  logic                 m2_valid_r;
  ppc_side_t            m2_side_r;
  logic                 m3_rdy;

  assign m2_rdy = !m2_valid_r || m3_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_valid_r <= 1'b0;
    end else if (m2_rdy) begin
      m2_valid_r <= m1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (m2_rdy) begin
      hx_r      <= (PH_W+1)'(cxh_r) - (PH_W+1)'(syh_r);
      hy_r      <= (PH_W+1)'(sxh_r) + (PH_W+1)'(cyh_r);
      lx_r      <= (PL_W+1)'(cxl_r) - (PL_W+1)'(syl_r);
      ly_r      <= (PL_W+1)'(sxl_r) + (PL_W+1)'(cyl_r);
      m2_side_r <= m1_side_r;
    end
  end

  // ---------------------------------------------------------------------
  // M3: full rotated term, scaled by 2^-30 with round half up
  // ---------------------------------------------------------------------
  localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) <<< (FRAC_SHIFT - 1);

  logic signed [SUM_W-1:0] fx_sum, fy_sum;
  logic signed [SUM_W-1:0] fx_rnd, fy_rnd;
  logic signed [TW-1:0]    tx_r, ty_r;
  logic                    m3_valid_r;
  ppc_side_t               m3_side_r;
  logic                    m4_rdy;

  assign fx_sum = (SUM_W'(hx_r) <<< LO_BITS) + SUM_W'(lx_r) + HALF_LSB;
  assign fy_sum = (SUM_W'(hy_r) <<< LO_BITS) + SUM_W'(ly_r) + HALF_LSB;
  assign fx_rnd = fx_sum >>> FRAC_SHIFT;
  assign fy_rnd = fy_sum >>> FRAC_SHIFT;

  assign m3_rdy = !m3_valid_r || m4_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_valid_r <= 1'b0;
    end else if (m3_rdy) begin
      m3_valid_r <= m2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (m3_rdy) begin
      tx_r      <= fx_rnd[TW-1:0];
      ty_r      <= fy_rnd[TW-1:0];
      m3_side_r <= m2_side_r;
    end
  end

  // ---------------------------------------------------------------------
  // M4 (output register): add base, clip to coordinate range
  // ---------------------------------------------------------------------
  // returns {clipped, value}
  function automatic logic [COORD_BITS:0] clip_coord(input logic signed [TW:0] v);
    logic top_ones;
    logic top_zeros;
    top_ones  = &v[TW:COORD_BITS-1];
    top_zeros = ~|v[TW:COORD_BITS-1];
    if (top_ones || top_zeros) begin
      return {1'b0, v[COORD_BITS-1:0]};
    end else if (v[TW]) begin
      return {1'b1, 1'b1, (COORD_BITS-1)'(0)};
    end else begin
      return {1'b1, 1'b0, {(COORD_BITS-1){1'b1}}};
    end
  endfunction

  logic signed [TW:0]     gx_sum, gy_sum;
  logic [COORD_BITS:0]    gx_clip, gy_clip;
  ppc_out_t               out_nxt;
  ppc_out_t               out_data_r;
  logic                   out_valid_r;

  assign gx_sum  = (TW+1)'(tx_r) + (TW+1)'(m3_side_r.base_x);
  assign gy_sum  = (TW+1)'(ty_r) + (TW+1)'(m3_side_r.base_y);
  assign gx_clip = clip_coord(gx_sum);
  assign gy_clip = clip_coord(gy_sum);

  always_comb begin
    out_nxt.global_x       = gx_clip[COORD_BITS-1:0];
    out_nxt.global_y       = gy_clip[COORD_BITS-1:0];
    out_nxt.global_heading = m3_side_r.global_heading;
    out_nxt.saturated      = gx_clip[COORD_BITS] | gy_clip[COORD_BITS];
  end

  assign m4_rdy = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (m4_rdy) begin
      out_valid_r <= m3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (m4_rdy) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: hdl/ppc_cordic_stage.sv
// One registered CORDIC micro-rotation stage of the pose composer.
// Carries the side fields along with the vector. Depends on ppc_pkg.
`default_nettype none

module ppc_cordic_stage import ppc_pkg::*; #(
  parameter int STAGE = 0
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire logic      valid_in,
  input  wire ppc_vec_t  vec_in,
  input  wire ppc_side_t side_in,
  output logic           valid_r,
  output ppc_vec_t       vec_r,
  output ppc_side_t      side_r
);

  logic signed [CW-1:0] x_in;
  logic signed [CW-1:0] y_in;
  logic signed [CW-1:0] z_in;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] ang;
  ppc_vec_t             vec_nxt;

  assign x_in = vec_in.x;
  assign y_in = vec_in.y;
  assign z_in = vec_in.z;
  assign dx   = y_in >>> STAGE;
  assign dy   = x_in >>> STAGE;
  assign ang  = CW'(ATAN_TABLE[STAGE]);

  // rotate toward zero residual angle
  always_comb begin
    if (!z_in[CW-1]) begin
      vec_nxt.x = x_in - dx;
      vec_nxt.y = y_in + dy;
      vec_nxt.z = z_in - ang;
    end else begin
      vec_nxt.x = x_in + dx;
      vec_nxt.y = y_in - dy;
      vec_nxt.z = z_in + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vec_r  <= vec_nxt;
      side_r <= side_in;
    end
  end

endmodule

`default_nettype wire
